// File: hw/rtl/snpam_pkg.sv
// shared types, constants and base complement for the allele match and recode block
`timescale 1ns / 1ps
package snpam_pkg;

   typedef enum logic [1:0] {
      CMD_SITE = 2'd0,
      CMD_ALT  = 2'd1,
      CMD_GENO = 2'd2,
      CMD_IDLE = 2'd3
   } cmd_type;

   localparam int          RSP_IDX_W    = 5;
   localparam logic [1:0]  GENO_INVALID = 2'd3;
   localparam logic [7:0]  CHAR_ZERO    = 8'h30;
   localparam logic [7:0]  BASE_A       = 8'h41;
   localparam logic [7:0]  BASE_C       = 8'h43;
   localparam logic [7:0]  BASE_G       = 8'h47;
   localparam logic [7:0]  BASE_T       = 8'h54;

   // strand flip, upper case only
   function automatic logic [7:0] complement_base(input logic [7:0] b);
      logic [7:0] r;
      case (b)
         BASE_A:  r = BASE_T;
         BASE_T:  r = BASE_A;
         BASE_C:  r = BASE_G;
         BASE_G:  r = BASE_C;
         default: r = b;
      endcase
      return r;
   endfunction

endpackage

// File: hw/rtl/snpam_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
interface snpam_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] ref_base;
   logic       ref_single;
   logic [7:0] expected_ref;
   logic [7:0] expected_alt;
   logic [7:0] alt_base;
   logic       alt_single;
   logic [7:0] first_allele_char;
   logic [7:0] second_allele_char;
   logic       genotype_well_formed;

   modport source (
      output valid, cmd, ref_base, ref_single, expected_ref, expected_alt, alt_base,
             alt_single, first_allele_char, second_allele_char, genotype_well_formed,
      input  ready
   );
   modport sink (
      input  valid, cmd, ref_base, ref_single, expected_ref, expected_alt, alt_base,
             alt_single, first_allele_char, second_allele_char, genotype_well_formed,
      output ready
   );
endinterface

interface snpam_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [4:0] ref_index;
   logic signed [4:0] alt_index;
   logic              site_usable;
   logic [1:0]        genotype_code;

   modport source (
      output valid, ref_index, alt_index, site_usable, genotype_code,
      input  ready
   );
   modport sink (
      input  valid, ref_index, alt_index, site_usable, genotype_code,
      output ready
   );
endinterface

// File: hw/rtl/snpam_site_track.sv
// per-site state: reference match, strand flip and alternate index search
`timescale 1ns / 1ps
module snpam_site_track #(
   parameter int  MAX_ALT_INDEX = 15,
   localparam int IdxW = $clog2(MAX_ALT_INDEX + 1) + 1,
   localparam int NumW = $clog2(MAX_ALT_INDEX + 2)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  snpam_pkg::cmd_type     cmd,
   input  logic [7:0]             ref_base,
   input  logic                   ref_single,
   input  logic [7:0]             expected_ref,
   input  logic [7:0]             expected_alt,
   input  logic [7:0]             alt_base,
   input  logic                   alt_single,
   output logic signed [IdxW-1:0] ref_idx_cur,
   output logic signed [IdxW-1:0] alt_idx_cur,
   output logic signed [IdxW-1:0] ref_idx_in,
   output logic signed [IdxW-1:0] alt_idx_in
);

   logic signed [IdxW-1:0] ref_idx_ff;
   logic signed [IdxW-1:0] alt_idx_ff;
   logic                   flip_ff, flip_in;
   logic                   search_ff, search_in;
   logic [NumW-1:0]        next_num_ff, next_num_in;
   logic [7:0]             panel_ref_ff, panel_ref_in;
   logic [7:0]             panel_alt_ff, panel_alt_in;

   logic [7:0]             ref_flip;
   logic [7:0]             alt_cmp;
   logic                   ref_hit, alt_hit;
   logic signed [IdxW-1:0] num_as_idx;

   assign ref_flip   = snpam_pkg::complement_base(ref_base);
   assign alt_cmp    = flip_ff ? snpam_pkg::complement_base(alt_base) : alt_base;
   assign ref_hit    = (ref_base == expected_ref) || (ref_flip == expected_ref);
   assign alt_hit    = (ref_base == expected_alt) || (ref_flip == expected_alt);
   // allele number is at most the limit here, so it fits below the sign bit
   assign num_as_idx = $signed({1'b0, next_num_ff[IdxW-2:0]});

   always_comb begin
      ref_idx_in   = ref_idx_ff;
      alt_idx_in   = alt_idx_ff;
      flip_in      = flip_ff;
      search_in    = search_ff;
      next_num_in  = next_num_ff;
      panel_ref_in = panel_ref_ff;
      panel_alt_in = panel_alt_ff;
      case (cmd)
         snpam_pkg::CMD_SITE: begin
            panel_ref_in = expected_ref;
            panel_alt_in = expected_alt;
            ref_idx_in   = '1;
            alt_idx_in   = '1;
            flip_in      = 1'b0;
            search_in    = 1'b0;
            next_num_in  = NumW'(1);
            if (ref_single) begin
               if (ref_hit) begin
                  ref_idx_in = '0;
               end else if (alt_hit) begin
                  alt_idx_in = '0;
               end
               flip_in   = (ref_flip == expected_ref) || (ref_flip == expected_alt);
               search_in = ref_hit || alt_hit;
            end
         end
         snpam_pkg::CMD_ALT: begin
            if (next_num_ff <= NumW'(MAX_ALT_INDEX)) begin
               next_num_in = next_num_ff + NumW'(1);
               if (search_ff && alt_single) begin
                  if (alt_cmp == panel_ref_ff && ref_idx_ff[IdxW-1]) begin
                     ref_idx_in = num_as_idx;
                  end else if (alt_cmp == panel_alt_ff && alt_idx_ff[IdxW-1]) begin
                     alt_idx_in = num_as_idx;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_idx_ff  <= '1;
         alt_idx_ff  <= '1;
         flip_ff     <= 1'b0;
         search_ff   <= 1'b0;
         next_num_ff <= NumW'(1);
      end else if (accept) begin
         ref_idx_ff  <= ref_idx_in;
         alt_idx_ff  <= alt_idx_in;
         flip_ff     <= flip_in;
         search_ff   <= search_in;
         next_num_ff <= next_num_in;
      end
   end

   // panel bases are only read once a site start has enabled the search
   always_ff @(posedge clock) begin
      if (accept) begin
         panel_ref_ff <= panel_ref_in;
         panel_alt_ff <= panel_alt_in;
      end
   end

   assign ref_idx_cur = ref_idx_ff;
   assign alt_idx_cur = alt_idx_ff;

endmodule

// File: hw/rtl/snpam_geno_recode.sv
// genotype recode to alternate allele count
`timescale 1ns / 1ps
module snpam_geno_recode #(
   parameter int  MAX_ALT_INDEX = 15,
   localparam int IdxW = $clog2(MAX_ALT_INDEX + 1) + 1
) (
   input  snpam_pkg::cmd_type     cmd,
   input  logic [7:0]             first_allele_char,
   input  logic [7:0]             second_allele_char,
   input  logic                   genotype_well_formed,
   input  logic signed [IdxW-1:0] ref_idx,
   input  logic signed [IdxW-1:0] alt_idx,
   output logic [1:0]             genotype_code
);

   // character minus '0' equals a set index
   function automatic logic allele_hit(input logic [7:0] c, input logic signed [IdxW-1:0] idx);
      logic [7:0] digit;
      digit = c - snpam_pkg::CHAR_ZERO;
      return !idx[IdxW-1] && (c >= snpam_pkg::CHAR_ZERO)
             && (digit == 8'(idx[IdxW-2:0]));
   endfunction

   logic g1_ref, g1_alt, g2_ref, g2_alt;
   logic usable;

   assign g1_ref = allele_hit(first_allele_char, ref_idx);
   assign g1_alt = allele_hit(first_allele_char, alt_idx);
   assign g2_ref = allele_hit(second_allele_char, ref_idx);
   assign g2_alt = allele_hit(second_allele_char, alt_idx);
   assign usable = !ref_idx[IdxW-1] && !alt_idx[IdxW-1];

   always_comb begin
      genotype_code = snpam_pkg::GENO_INVALID;
      if (cmd == snpam_pkg::CMD_GENO && genotype_well_formed && usable
          && (g1_ref || g1_alt) && (g2_ref || g2_alt)) begin
         genotype_code = {1'b0, g1_alt} + {1'b0, g2_alt};
      end
   end

endmodule

// File: hw/rtl/snp_allele_match_genotype_recode_core.sv
// top level: allele match with strand flip and genotype recode
//
//   channel  | dir | contents
//   ---------+-----+-----------------------------------------------------------
//   req_ch   | in  | cmd, site bases, one alternate base, genotype characters
//   rsp_ch   | out | ref_index, alt_index, site_usable, genotype_code
//
// one item per cycle unless rsp_ch stalls; a result is valid the cycle after its item.
// the site state and the result register are loaded at the same edge.
// reset is synchronous: indices to minus one, flip and search off, allele number one.
// a stalled result holds in the output register while req_ch.ready follows rsp_ch.ready.
`timescale 1ns / 1ps
module snp_allele_match_genotype_recode_core #(
   parameter int MAX_ALT_INDEX = 15
) (
   input  logic               clock,
   input  logic               reset,
   snpam_req_if.sink          req_ch,
   snpam_rsp_if.source        rsp_ch
);

   localparam int IdxW = $clog2(MAX_ALT_INDEX + 1) + 1;

   snpam_pkg::cmd_type     cmd;
   logic                   accept;
   logic signed [IdxW-1:0] ref_idx_cur, alt_idx_cur;
   logic signed [IdxW-1:0] ref_idx_in, alt_idx_in;
   logic signed [31:0]     ref_wide, alt_wide;
   logic [1:0]             geno_in;

   logic                                    rsp_valid_ff;
   logic signed [snpam_pkg::RSP_IDX_W-1:0]  rsp_ref_ff, rsp_ref_in;
   logic signed [snpam_pkg::RSP_IDX_W-1:0]  rsp_alt_ff, rsp_alt_in;
   logic                                    rsp_usable_ff, rsp_usable_in;
   logic [1:0]                              rsp_geno_ff;

   assign cmd          = snpam_pkg::cmd_type'(req_ch.cmd);
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   snpam_site_track #(.MAX_ALT_INDEX(MAX_ALT_INDEX)) u_site (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .cmd          (cmd),
      .ref_base     (req_ch.ref_base),
      .ref_single   (req_ch.ref_single),
      .expected_ref (req_ch.expected_ref),
      .expected_alt (req_ch.expected_alt),
      .alt_base     (req_ch.alt_base),
      .alt_single   (req_ch.alt_single),
      .ref_idx_cur  (ref_idx_cur),
      .alt_idx_cur  (alt_idx_cur),
      .ref_idx_in   (ref_idx_in),
      .alt_idx_in   (alt_idx_in)
   );

   // genotype items leave the state untouched, so the current indices serve
   snpam_geno_recode #(.MAX_ALT_INDEX(MAX_ALT_INDEX)) u_geno (
      .cmd                  (cmd),
      .first_allele_char    (req_ch.first_allele_char),
      .second_allele_char   (req_ch.second_allele_char),
      .genotype_well_formed (req_ch.genotype_well_formed),
      .ref_idx              (ref_idx_cur),
      .alt_idx              (alt_idx_cur),
      .genotype_code        (geno_in)
   );

   // sign extend, then keep the low bits of the result field
   assign ref_wide      = 32'(ref_idx_in);
   assign alt_wide      = 32'(alt_idx_in);
   assign rsp_ref_in    = ref_wide[snpam_pkg::RSP_IDX_W-1:0];
   assign rsp_alt_in    = alt_wide[snpam_pkg::RSP_IDX_W-1:0];
   assign rsp_usable_in = !ref_idx_in[IdxW-1] && !alt_idx_in[IdxW-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ref_ff    <= rsp_ref_in;
         rsp_alt_ff    <= rsp_alt_in;
         rsp_usable_ff <= rsp_usable_in;
         rsp_geno_ff   <= geno_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.ref_index     = rsp_ref_ff;
   assign rsp_ch.alt_index     = rsp_alt_ff;
   assign rsp_ch.site_usable   = rsp_usable_ff;
   assign rsp_ch.genotype_code = rsp_geno_ff;

endmodule

// File: hw/rtl/snpam_checker.sv
// port-level checks for the core, attached by bind
`timescale 1ns / 1ps
module snpam_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_site_usable,
   input logic [1:0] rsp_genotype_code
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_item_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item gave no result");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output register");

   a_geno_needs_site: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_genotype_code != snpam_pkg::GENO_INVALID |-> rsp_site_usable)
      else $error("genotype recoded on an unusable site");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind snp_allele_match_genotype_recode_core snpam_checker u_snpam_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_site_usable   (rsp_ch.site_usable),
   .rsp_genotype_code (rsp_ch.genotype_code)
);

// File: tb/testbench.sv
// self-checking testbench for the allele match and genotype recode core
`timescale 1ns / 1ps
module testbench;

   localparam int MAX_ALT     = 15;
   localparam int RAND_ITEMS  = 1900;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 10;
   localparam int HOLD_CYCLES = 120;

   typedef struct packed {
      snpam_pkg::cmd_type cmd;
      logic [7:0] ref_base;
      logic       ref_single;
      logic [7:0] expected_ref;
      logic [7:0] expected_alt;
      logic [7:0] alt_base;
      logic       alt_single;
      logic [7:0] first_allele_char;
      logic [7:0] second_allele_char;
      logic       genotype_well_formed;
   } allele_req_type;

   typedef struct packed {
      logic signed [4:0] ref_index;
      logic signed [4:0] alt_index;
      logic              site_usable;
      logic [1:0]        genotype_code;
   } allele_rsp_type;

   logic clock;
   logic reset;

   snpam_req_if req_ch ();
   snpam_rsp_if rsp_ch ();

   snp_allele_match_genotype_recode_core #(
      .MAX_ALT_INDEX (MAX_ALT)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   allele_req_type pending_q[$];
   allele_rsp_type expected_rsp_q[$];
   allele_req_type next_req;

   int total_items;
   int items_taken;
   int results_seen;
   int err_cnt;
   int cycle_cnt;
   int hold_left;
   bit hold_done;
   int sites_seen;
   int usable_seen;
   int geno_tally[4];

   // predictor state
   logic signed [4:0] match_ref_idx;
   logic signed [4:0] match_alt_idx;
   logic              strand_flipped;
   logic              search_open;
   int                next_allele;
   logic [7:0]        panel_ref;
   logic [7:0]        panel_alt;

   function automatic logic [7:0] strand_flip(input logic [7:0] b);
      case (b)
         snpam_pkg::BASE_A: return snpam_pkg::BASE_T;
         snpam_pkg::BASE_T: return snpam_pkg::BASE_A;
         snpam_pkg::BASE_C: return snpam_pkg::BASE_G;
         snpam_pkg::BASE_G: return snpam_pkg::BASE_C;
         default:           return b;
      endcase
   endfunction

   function automatic allele_rsp_type recode_step(input allele_req_type it);
      allele_rsp_type res;
      logic [7:0]  fr;
      logic [7:0]  a;
      int          n;
      int          g1;
      int          g2;
      int          n_ok;
      int          n_alt;
      res.genotype_code = snpam_pkg::GENO_INVALID;
      case (it.cmd)
         snpam_pkg::CMD_SITE: begin
            fr = strand_flip(it.ref_base);
            panel_ref = it.expected_ref;
            panel_alt = it.expected_alt;
            match_ref_idx = '1;
            match_alt_idx = '1;
            strand_flipped = 1'b0;
            search_open = 1'b0;
            next_allele = 1;
            if (it.ref_single) begin
               if (it.ref_base == panel_ref || fr == panel_ref)
                  match_ref_idx = '0;
               else if (it.ref_base == panel_alt || fr == panel_alt)
                  match_alt_idx = '0;
               strand_flipped = (fr == panel_ref || fr == panel_alt);
               search_open = (match_ref_idx >= 0 || match_alt_idx >= 0);
            end
            sites_seen++;
         end
         snpam_pkg::CMD_ALT: begin
            if (next_allele <= MAX_ALT) begin
               n = next_allele;
               next_allele++;
               if (search_open && it.alt_single) begin
                  a = strand_flipped ? strand_flip(it.alt_base) : it.alt_base;
                  if (a == panel_ref && match_ref_idx < 0)
                     match_ref_idx = 5'(n);
                  else if (a == panel_alt && match_alt_idx < 0)
                     match_alt_idx = 5'(n);
               end
            end
         end
         snpam_pkg::CMD_GENO: begin
            if (it.genotype_well_formed && match_ref_idx >= 0 && match_alt_idx >= 0) begin
               g1 = int'(it.first_allele_char) - int'(snpam_pkg::CHAR_ZERO);
               g2 = int'(it.second_allele_char) - int'(snpam_pkg::CHAR_ZERO);
               n_ok = 0;
               n_alt = 0;
               if (g1 == match_ref_idx || g1 == match_alt_idx) begin
                  n_ok++;
                  if (g1 == match_alt_idx) n_alt++;
               end
               if (g2 == match_ref_idx || g2 == match_alt_idx) begin
                  n_ok++;
                  if (g2 == match_alt_idx) n_alt++;
               end
               if (n_ok == 2) res.genotype_code = 2'(n_alt);
            end
         end
         default: ;
      endcase
      res.ref_index = match_ref_idx;
      res.alt_index = match_alt_idx;
      res.site_usable = (match_ref_idx >= 0 && match_alt_idx >= 0);
      return res;
   endfunction

   // every field random, so fields unused by a command still toggle all bits
   function automatic allele_req_type rand_fill(input snpam_pkg::cmd_type c);
      allele_req_type it;
      it.cmd = c;
      it.ref_base = 8'($urandom);
      it.ref_single = 1'($urandom);
      it.expected_ref = 8'($urandom);
      it.expected_alt = 8'($urandom);
      it.alt_base = 8'($urandom);
      it.alt_single = 1'($urandom);
      it.first_allele_char = 8'($urandom);
      it.second_allele_char = 8'($urandom);
      it.genotype_well_formed = 1'($urandom);
      return it;
   endfunction

   function automatic logic [7:0] pick_nucleotide();
      case ($urandom_range(0, 3))
         0:       return snpam_pkg::BASE_A;
         1:       return snpam_pkg::BASE_C;
         2:       return snpam_pkg::BASE_G;
         default: return snpam_pkg::BASE_T;
      endcase
   endfunction

   function automatic logic [7:0] pick_site_base(input logic [7:0] er, input logic [7:0] ea);
      case ($urandom_range(0, 5))
         0:       return er;
         1:       return strand_flip(er);
         2:       return ea;
         3:       return strand_flip(ea);
         4:       return pick_nucleotide();
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_geno_char();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return snpam_pkg::CHAR_ZERO + 8'($urandom_range(0, 2));
      if (r < 9) return snpam_pkg::CHAR_ZERO + 8'($urandom_range(0, 17));
      return 8'($urandom);
   endfunction

   task automatic queue_req(input allele_req_type it);
      pending_q.insert(pending_q.size(), it);
   endtask

   task automatic add_site(input logic [7:0] rb, input logic rs, input logic [7:0] er,
                           input logic [7:0] ea);
      allele_req_type it;
      it = rand_fill(snpam_pkg::CMD_SITE);
      it.ref_base = rb;
      it.ref_single = rs;
      it.expected_ref = er;
      it.expected_alt = ea;
      queue_req(it);
   endtask

   task automatic add_alt(input logic [7:0] ab, input logic s);
      allele_req_type it;
      it = rand_fill(snpam_pkg::CMD_ALT);
      it.alt_base = ab;
      it.alt_single = s;
      queue_req(it);
   endtask

   task automatic add_geno(input logic [7:0] c1, input logic [7:0] c2, input logic wf);
      allele_req_type it;
      it = rand_fill(snpam_pkg::CMD_GENO);
      it.first_allele_char = c1;
      it.second_allele_char = c2;
      it.genotype_well_formed = wf;
      queue_req(it);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // sender: a new item only once the current one has gone
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (pending_q.size() != 0 && $urandom_range(0, 99) >= (items_taken < total_items / 3 ? 31 :
             items_taken < 2 * total_items / 3 ? 59 : 0)) begin
            next_req = pending_q.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.cmd <= next_req.cmd;
            req_ch.ref_base <= next_req.ref_base;
            req_ch.ref_single <= next_req.ref_single;
            req_ch.expected_ref <= next_req.expected_ref;
            req_ch.expected_alt <= next_req.expected_alt;
            req_ch.alt_base <= next_req.alt_base;
            req_ch.alt_single <= next_req.alt_single;
            req_ch.first_allele_char <= next_req.first_allele_char;
            req_ch.second_allele_char <= next_req.second_allele_char;
            req_ch.genotype_well_formed <= next_req.genotype_well_formed;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // receiver, with one long hold-off late in the run to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= (hold_left == 1);
      end else if (!hold_done && items_taken >= 5 * total_items / 6) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= $urandom_range(0, 99) >= (items_taken < total_items / 3 ? 59 :
                         items_taken < 2 * total_items / 3 ? 31 : 0);
      end
   end

   always @(posedge clock) begin
      allele_req_type seen_req;
      allele_rsp_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            seen_req.cmd = snpam_pkg::cmd_type'(req_ch.cmd);
            seen_req.ref_base = req_ch.ref_base;
            seen_req.ref_single = req_ch.ref_single;
            seen_req.expected_ref = req_ch.expected_ref;
            seen_req.expected_alt = req_ch.expected_alt;
            seen_req.alt_base = req_ch.alt_base;
            seen_req.alt_single = req_ch.alt_single;
            seen_req.first_allele_char = req_ch.first_allele_char;
            seen_req.second_allele_char = req_ch.second_allele_char;
            seen_req.genotype_well_formed = req_ch.genotype_well_formed;
            expected_rsp_q.insert(expected_rsp_q.size(), recode_step(seen_req));
            items_taken <= items_taken + 1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen <= results_seen + 1;
            if (expected_rsp_q.size() == 0) begin
               $error("result with nothing expected: ref_index %0d alt_index %0d",
                      rsp_ch.ref_index, rsp_ch.alt_index);
               err_cnt++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_ch.ref_index !== want.ref_index) begin
                  $error("ref_index: expected %0d, got %0d", want.ref_index, rsp_ch.ref_index);
                  err_cnt++;
               end
               if (rsp_ch.alt_index !== want.alt_index) begin
                  $error("alt_index: expected %0d, got %0d", want.alt_index, rsp_ch.alt_index);
                  err_cnt++;
               end
               if (rsp_ch.site_usable !== want.site_usable) begin
                  $error("site_usable: expected %0d, got %0d", want.site_usable,
                         rsp_ch.site_usable);
                  err_cnt++;
               end
               if (rsp_ch.genotype_code !== want.genotype_code) begin
                  $error("genotype_code: expected %0d, got %0d", want.genotype_code,
                         rsp_ch.genotype_code);
                  err_cnt++;
               end
               if (want.site_usable) usable_seen++;
               geno_tally[want.genotype_code]++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int directed_cnt;
      int n_alt;
      int n_geno;
      logic [7:0] er;
      logic [7:0] ea;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.cmd = snpam_pkg::CMD_IDLE;
      req_ch.ref_base = '0;
      req_ch.ref_single = 1'b0;
      req_ch.expected_ref = '0;
      req_ch.expected_alt = '0;
      req_ch.alt_base = '0;
      req_ch.alt_single = 1'b0;
      req_ch.first_allele_char = '0;
      req_ch.second_allele_char = '0;
      req_ch.genotype_well_formed = 1'b0;
      rsp_ch.ready = 1'b0;
      items_taken = 0;
      results_seen = 0;
      err_cnt = 0;
      cycle_cnt = 0;
      sites_seen = 0;
      usable_seen = 0;
      geno_tally = '{0, 0, 0, 0};
      match_ref_idx = '1;
      match_alt_idx = '1;
      strand_flipped = 1'b0;
      search_open = 1'b0;
      next_allele = 1;
      panel_ref = '0;
      panel_alt = '0;

      // before any site: alternates only count, genotypes are invalid
      add_alt(snpam_pkg::BASE_A, 1'b1);
      add_geno(snpam_pkg::CHAR_ZERO, snpam_pkg::CHAR_ZERO, 1'b1);
      queue_req('1);
      // plain site, then all genotype outcomes
      add_site(snpam_pkg::BASE_A, 1'b1, snpam_pkg::BASE_A, snpam_pkg::BASE_G);
      add_alt(snpam_pkg::BASE_G, 1'b1);
      add_geno(snpam_pkg::CHAR_ZERO, snpam_pkg::CHAR_ZERO, 1'b1);
      add_geno(snpam_pkg::CHAR_ZERO, snpam_pkg::CHAR_ZERO + 8'd1, 1'b1);
      add_geno(snpam_pkg::CHAR_ZERO + 8'd1, snpam_pkg::CHAR_ZERO + 8'd1, 1'b1);
      add_geno(snpam_pkg::CHAR_ZERO + 8'd1, snpam_pkg::CHAR_ZERO, 1'b1);
      add_geno(snpam_pkg::CHAR_ZERO + 8'd2, snpam_pkg::CHAR_ZERO, 1'b1);
      add_geno(snpam_pkg::CHAR_ZERO, snpam_pkg::CHAR_ZERO + 8'd1, 1'b0);
      add_geno(8'hFF, 8'h00, 1'b1);
      // flipped strand, with a multi-character alternate taking index one
      add_site(snpam_pkg::BASE_T, 1'b1, snpam_pkg::BASE_A, snpam_pkg::BASE_C);
      add_alt(snpam_pkg::BASE_G, 1'b0);
      add_alt(snpam_pkg::BASE_G, 1'b1);
      add_geno(snpam_pkg::CHAR_ZERO, snpam_pkg::CHAR_ZERO + 8'd2, 1'b1);
      // reference base matching the panel alternate
      add_site(snpam_pkg::BASE_C, 1'b1, snpam_pkg::BASE_A, snpam_pkg::BASE_C);
      add_alt(snpam_pkg::BASE_A, 1'b1);
      add_geno(snpam_pkg::CHAR_ZERO + 8'd1, snpam_pkg::CHAR_ZERO + 8'd1, 1'b1);
      // multi-character reference switches the search off
      add_site(snpam_pkg::BASE_A, 1'b0, snpam_pkg::BASE_A, snpam_pkg::BASE_G);
      add_alt(snpam_pkg::BASE_G, 1'b1);
      add_geno(snpam_pkg::CHAR_ZERO, snpam_pkg::CHAR_ZERO + 8'd1, 1'b1);
      // no match at all, then a flip set by the panel reference side
      add_site(8'h00, 1'b1, 8'hFF, snpam_pkg::BASE_A);
      add_site(snpam_pkg::BASE_A, 1'b1, snpam_pkg::BASE_T, snpam_pkg::BASE_A);
      add_alt(snpam_pkg::BASE_A, 1'b1);
      directed_cnt = pending_q.size();

      while (pending_q.size() < directed_cnt + RAND_ITEMS) begin
         if ($urandom_range(0, 9) < 8) begin
            er = pick_nucleotide();
            ea = pick_nucleotide();
            add_site(pick_site_base(er, ea), $urandom_range(0, 9) != 0, er, ea);
            n_alt = ($urandom_range(0, 19) == 0) ? $urandom_range(14, 17) : $urandom_range(1, 3);
            for (int k = 0; k < n_alt; k++)
               add_alt(pick_site_base(er, ea), $urandom_range(0, 9) != 0);
            n_geno = $urandom_range(2, 8);
            for (int k = 0; k < n_geno; k++)
               add_geno(pick_geno_char(), pick_geno_char(), $urandom_range(0, 9) != 0);
         end else begin
            n_alt = $urandom_range(1, 4);
            for (int k = 0; k < n_alt; k++)
               queue_req(rand_fill(snpam_pkg::cmd_type'($urandom_range(0, 3))));
         end
      end
      total_items = pending_q.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (items_taken < total_items || expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (expected_rsp_q.size() != 0) begin
         $error("%0d expected results never arrived", expected_rsp_q.size());
         err_cnt++;
      end

      $display("run covered %0d items (%0d site starts), %0d results, %0d on a usable site",
               total_items, sites_seen, results_seen, usable_seen);
      $display("genotype codes seen: 0:%0d 1:%0d 2:%0d invalid:%0d",
               geno_tally[0], geno_tally[1], geno_tally[2], geno_tally[3]);
      if (err_cnt == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/snpam_pkg.sv
hw/rtl/snpam_if.sv
hw/rtl/snpam_site_track.sv
hw/rtl/snpam_geno_recode.sv
hw/rtl/snp_allele_match_genotype_recode_core.sv
hw/rtl/snpam_checker.sv
tb/testbench.sv
